// ===== hw/rtl/ufe_pkg.sv =====
// ---------------------------------------------------------------------------
// ufe_pkg: shared types and constants of the union-find engine
// Element table geometry, entry encoding and the request/result structs.
// ---------------------------------------------------------------------------
package ufe_pkg;

  // table geometry
  localparam int N_ELEMS = 1024;
  localparam int ELEM_W  = $clog2(N_ELEMS);
  localparam int ENTRY_W = 12;

  // entry: parent index when >= 0, negative set size at a root
  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic [ELEM_W-1:0]         elem_t;

  localparam entry_t ENTRY_INIT = '1;

  // operation codes
  localparam logic FUNC_FIND  = 1'b0;
  localparam logic FUNC_UNION = 1'b1;

  typedef struct packed {
    logic  func;
    elem_t elem_a;
    elem_t elem_b;
  } in_item_t;

  typedef struct packed {
    elem_t root;
    logic  merged;
  } out_item_t;

endpackage

// ===== hw/rtl/union_find_engine.sv =====
// ---------------------------------------------------------------------------
// union_find_engine: disjoint-set engine with path compression
// Holds a table of parent-or-size entries in one synchronous memory, walks
// parent chains to a root, rewrites the walked path and links roots on union.
// ---------------------------------------------------------------------------
//
//  channel | ports                        | carries
//  --------+------------------------------+-----------------------------------
//  input   | in_valid, in_stall, in_data  | func, elem_a, elem_b per transfer
//  result  | out_valid, out_stall, out_data | root, merged per transfer
//
//  A find reads the parent chain to the root, walks the path again to point
//  each entry on it at the root, then loads the result. A union does so for
//  elem_a, then elem_b, and if the roots differ links the first under the second.
//  After reset the table is swept to all -1, one entry a cycle, over all 1024
//  entries with in_stall high. One request is in work at a time; a result waits
//  in the output register while the next request is accepted; out_stall delays its load.

module union_find_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ufe_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ufe_pkg::out_item_t  out_data
);
  import ufe_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_COMP  = 3'd3;
  localparam logic [2:0] ST_LINK  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // table memory and its ports
  entry_t table_mem [N_ELEMS];
  entry_t rd_data_r;
  logic   rd_en;
  elem_t  rd_addr;
  logic   wr_en;
  elem_t  wr_addr;
  entry_t wr_data;

  // control and request registers
  logic [2:0] state_r, state_nxt;
  elem_t      clr_cnt_r, clr_cnt_nxt;
  logic       func_r, func_nxt;
  logic       phase_r, phase_nxt;
  elem_t      elem_b_r, elem_b_nxt;
  elem_t      cur_r, cur_nxt;
  elem_t      start_r, start_nxt;
  elem_t      walk_r, walk_nxt;
  elem_t      root_r, root_nxt;
  entry_t     rsize_r, rsize_nxt;
  elem_t      ra_r, ra_nxt;
  entry_t     rasize_r, rasize_nxt;
  logic       merged_r, merged_nxt;

  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       out_load;

  elem_t      parent;

  assign parent   = rd_data_r[ELEM_W-1:0];
  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer: clear sweep, root walk, path rewrite, link
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    func_nxt    = func_r;
    phase_nxt   = phase_r;
    elem_b_nxt  = elem_b_r;
    cur_nxt     = cur_r;
    start_nxt   = start_r;
    walk_nxt    = walk_r;
    root_nxt    = root_r;
    rsize_nxt   = rsize_r;
    ra_nxt      = ra_r;
    rasize_nxt  = rasize_r;
    merged_nxt  = merged_r;
    rd_en       = 1'b0;
    rd_addr     = cur_r;
    wr_en       = 1'b0;
    wr_addr     = walk_r;
    wr_data     = ENTRY_INIT;
    case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = ENTRY_INIT;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ELEM_W'(N_ELEMS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_data.func;
          elem_b_nxt = in_data.elem_b;
          cur_nxt    = in_data.elem_a;
          start_nxt  = in_data.elem_a;
          phase_nxt  = 1'b0;
          rd_en      = 1'b1;
          rd_addr    = in_data.elem_a;
          state_nxt  = ST_WALK;
        end
      end
      ST_WALK: begin
        rd_en = 1'b1;
        if (rd_data_r[ENTRY_W-1]) begin
          // reached a root: restart at the path head to compress
          root_nxt  = cur_r;
          rsize_nxt = rd_data_r;
          walk_nxt  = start_r;
          rd_addr   = start_r;
          state_nxt = ST_COMP;
        end else begin
          cur_nxt = parent;
          rd_addr = parent;
        end
      end
      ST_COMP: begin
        if (walk_r == root_r) begin
          if (func_r == FUNC_UNION && !phase_r) begin
            // first root found, walk the second element
            ra_nxt     = root_r;
            rasize_nxt = rsize_r;
            phase_nxt  = 1'b1;
            cur_nxt    = elem_b_r;
            start_nxt  = elem_b_r;
            rd_en      = 1'b1;
            rd_addr    = elem_b_r;
            state_nxt  = ST_WALK;
          end else if (func_r == FUNC_UNION && ra_r != root_r) begin
            // second root takes the combined size
            wr_en      = 1'b1;
            wr_addr    = root_r;
            wr_data    = rasize_r + rsize_r;
            merged_nxt = 1'b1;
            state_nxt  = ST_LINK;
          end else begin
            merged_nxt = 1'b0;
            state_nxt  = ST_DONE;
          end
        end else begin
          // point this path entry at the root, fetch the next one
          wr_en    = 1'b1;
          wr_addr  = walk_r;
          wr_data  = entry_t'({{(ENTRY_W-ELEM_W){1'b0}}, root_r});
          rd_en    = 1'b1;
          rd_addr  = parent;
          walk_nxt = parent;
        end
      end
      ST_LINK: begin
        // first root goes under the second
        wr_en     = 1'b1;
        wr_addr   = ra_r;
        wr_data   = entry_t'({{(ENTRY_W-ELEM_W){1'b0}}, root_r});
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= table_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request payload and walk registers
  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    phase_r  <= phase_nxt;
    elem_b_r <= elem_b_nxt;
    cur_r    <= cur_nxt;
    start_r  <= start_nxt;
    walk_r   <= walk_nxt;
    root_r   <= root_nxt;
    rsize_r  <= rsize_nxt;
    ra_r     <= ra_nxt;
    rasize_r <= rasize_nxt;
    merged_r <= merged_nxt;
    if (out_load) begin
      out_data_r.root   <= root_r;
      out_data_r.merged <= merged_r;
    end
  end

  // checks
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r != ST_IDLE && state_r != ST_DONE))
    else $error("table written outside a request");

  a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write of one entry in one cycle");

  a_merged_union: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && merged_r) |-> (func_r == FUNC_UNION))
    else $error("merge reported for a find");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (in_stall && !out_valid_r))
    else $error("transfer during table clear");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_data_r))
    else $error("pending result overwritten");

endmodule
